// File: rtl/core/stok_pkg.sv
// Shared types and constants for the source tokenizer.
// Token record, push group and queue sizing. No dependencies.
package stok_pkg;

  // Output field widths
  localparam int unsigned IDX_W  = 24;
  localparam int unsigned LINE_W = 20;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned VAL_W  = 32;

  // Default counter and accumulator widths
  localparam int unsigned INDEX_BITS_DEF  = 24;
  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  // Token queue between lexer and output port
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_OP      = 3'd2,
    KIND_INT     = 3'd3,
    KIND_OPEN    = 3'd4,
    KIND_CLOSE   = 3'd5,
    KIND_ASSIGN  = 3'd6,
    KIND_INVALID = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  start_index;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [LEN_W-1:0]  length;
    logic [VAL_W-1:0]  value;
    logic              overflow;
    logic              last;
  } tok_t;

  // Up to two tokens per transaction, tok0 first
  typedef struct packed {
    logic [1:0] n;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

endpackage

// File: rtl/core/stok_lexer.sv
// Lexer core: pending-token state, position counters and token building.
// Depends on stok_pkg.
module stok_lexer import stok_pkg::*; #(
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       cmd_i,
  input  logic [7:0] char_byte_i,
  output push_t      push_o
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_INT   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_COLON = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  localparam int unsigned IW  = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
  localparam int unsigned LW  = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
  localparam int unsigned CW  = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;
  localparam int unsigned NW  = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
  localparam int unsigned VW  = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
  localparam int unsigned VW4 = VALUE_BITS + 4;

  function automatic logic [IDX_W-1:0] clamp_idx(logic [INDEX_BITS-1:0] v);
    logic [IW-1:0] e;
    e = IW'(v);
    return (e > IW'({IDX_W{1'b1}})) ? {IDX_W{1'b1}} : e[IDX_W-1:0];
  endfunction

  function automatic logic [LINE_W-1:0] clamp_line(logic [LINE_BITS-1:0] v);
    logic [LW-1:0] e;
    e = LW'(v);
    return (e > LW'({LINE_W{1'b1}})) ? {LINE_W{1'b1}} : e[LINE_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(logic [COLUMN_BITS-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return (e > CW'({COL_W{1'b1}})) ? {COL_W{1'b1}} : e[COL_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(logic [INDEX_BITS-1:0] v);
    logic [NW-1:0] e;
    e = NW'(v);
    return (e > NW'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : e[LEN_W-1:0];
  endfunction

  logic [1:0]             mode_q, mode_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [INDEX_BITS-1:0]  pos_q, pos_d, st_idx_q, st_idx_d;
  logic [LINE_BITS-1:0]   line_q, line_d, st_line_q, st_line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, st_col_q, st_col_d;

  logic is_end, is_dec, is_alpha, is_ws, is_op, is_nl;
  logic [INDEX_BITS-1:0]  pos_inc, len_now, len_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [VALUE_BITS-1:0]  acc_base;
  logic                   ovf_base;
  logic [VW4-1:0]         acc_wide;
  logic [VW-1:0]          acc_ext;
  logic                   acc_sat;
  logic                   first_v, sec_v;
  tok_t                   flush_tok, sec_tok;
  kind_e                  single_kind;

  always_comb begin
    is_end   = cmd_i || (char_byte_i == CH_NUL);
    is_dec   = (char_byte_i >= CH_0) && (char_byte_i <= CH_9);
    is_alpha = ((char_byte_i >= CH_LC_A) && (char_byte_i <= CH_LC_Z)) ||
               ((char_byte_i >= CH_UC_A) && (char_byte_i <= CH_UC_Z)) ||
               (char_byte_i == CH_US);
    is_nl    = (char_byte_i == CH_NL);
    is_ws    = (char_byte_i == CH_SPACE) || (char_byte_i == CH_TAB) || is_nl;
    is_op    = (char_byte_i == CH_PLUS) || (char_byte_i == CH_MINUS) ||
               (char_byte_i == CH_STAR) || (char_byte_i == CH_SLASH);

    pos_inc  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
    line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
    col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;
    len_now  = (pos_q >= st_idx_q) ? pos_q - st_idx_q : '0;
    len_inc  = (pos_inc >= st_idx_q) ? pos_inc - st_idx_q : '0;

    // value*10 + digit, compared against the accumulator maximum
    acc_base = ((mode_q == MODE_INT) && is_dec) ? acc_q : '0;
    ovf_base = ((mode_q == MODE_INT) && is_dec) ? ovf_q : 1'b0;
    acc_wide = (VW4'(acc_base) << 3) + (VW4'(acc_base) << 1) +
               VW4'(char_byte_i[3:0]);
    acc_sat  = ovf_base || (acc_wide[VW4-1 -: 4] != 4'd0);

    acc_ext  = VW'(acc_q);

    // pending token, emitted ahead of whatever this byte produces
    flush_tok              = '0;
    flush_tok.start_index  = clamp_idx(st_idx_q);
    flush_tok.start_line   = clamp_line(st_line_q);
    flush_tok.start_column = clamp_col(st_col_q);
    flush_tok.length       = clamp_len(len_now);
    case (mode_q)
      MODE_INT: begin
        flush_tok.kind = KIND_INT;
        if (acc_ext > VW'({VAL_W{1'b1}})) begin
          flush_tok.value    = {VAL_W{1'b1}};
          flush_tok.overflow = 1'b1;
        end else begin
          flush_tok.value    = acc_ext[VAL_W-1:0];
          flush_tok.overflow = ovf_q;
        end
      end
      MODE_IDENT: flush_tok.kind = KIND_IDENT;
      MODE_COLON: flush_tok.kind = KIND_INVALID;
      default:    flush_tok.kind = KIND_END;
    endcase

    if (is_op) begin
      single_kind = KIND_OP;
    end else if (char_byte_i == CH_LPAR) begin
      single_kind = KIND_OPEN;
    end else if (char_byte_i == CH_RPAR) begin
      single_kind = KIND_CLOSE;
    end else begin
      single_kind = KIND_INVALID;
    end

    mode_d    = mode_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    pos_d     = pos_inc;
    line_d    = is_nl ? line_inc : line_q;
    col_d     = is_nl ? '0 : col_inc;
    st_idx_d  = st_idx_q;
    st_line_d = st_line_q;
    st_col_d  = st_col_q;
    first_v   = 1'b0;
    sec_v     = 1'b0;

    sec_tok              = '0;
    sec_tok.start_index  = clamp_idx(pos_q);
    sec_tok.start_line   = clamp_line(line_q);
    sec_tok.start_column = clamp_col(col_q);

    if (is_end) begin
      // end token at the current position, position holds
      first_v        = (mode_q != MODE_IDLE);
      sec_v          = 1'b1;
      sec_tok.kind   = KIND_END;
      mode_d         = MODE_IDLE;
      pos_d          = pos_q;
      line_d         = line_q;
      col_d          = col_q;
      st_idx_d       = pos_q;
      st_line_d      = line_q;
      st_col_d       = col_q;
    end else if ((mode_q == MODE_INT) && is_dec) begin
      acc_d = acc_sat ? '1 : acc_wide[VALUE_BITS-1:0];
      ovf_d = acc_sat;
    end else if ((mode_q == MODE_IDENT) && (is_alpha || is_dec)) begin
      mode_d = MODE_IDENT;
    end else if ((mode_q == MODE_COLON) && (char_byte_i == CH_EQ)) begin
      sec_v                = 1'b1;
      sec_tok.kind         = KIND_ASSIGN;
      sec_tok.start_index  = clamp_idx(st_idx_q);
      sec_tok.start_line   = clamp_line(st_line_q);
      sec_tok.start_column = clamp_col(st_col_q);
      sec_tok.length       = clamp_len(len_inc);
      mode_d               = MODE_IDLE;
    end else begin
      first_v = (mode_q != MODE_IDLE);
      mode_d  = MODE_IDLE;
      if (!is_ws) begin
        st_idx_d  = pos_q;
        st_line_d = line_q;
        st_col_d  = col_q;
        if (is_dec) begin
          mode_d = MODE_INT;
          acc_d  = acc_wide[VALUE_BITS-1:0];
          ovf_d  = 1'b0;
        end else if (is_alpha) begin
          mode_d = MODE_IDENT;
        end else if (char_byte_i == CH_COLON) begin
          mode_d = MODE_COLON;
        end else begin
          sec_v          = 1'b1;
          sec_tok.kind   = single_kind;
          sec_tok.length = LEN_W'(1);
        end
      end
    end

    sec_tok.last   = 1'b1;
    flush_tok.last = !sec_v;

    push_o.n    = fire_i ? (2'(first_v) + 2'(sec_v)) : 2'd0;
    push_o.tok0 = first_v ? flush_tok : sec_tok;
    push_o.tok1 = sec_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      pos_q     <= '0;
      line_q    <= '0;
      col_q     <= '0;
      st_idx_q  <= '0;
      st_line_q <= '0;
      st_col_q  <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      ovf_q     <= ovf_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
      col_q     <= col_d;
      st_idx_q  <= st_idx_d;
      st_line_q <= st_line_d;
      st_col_q  <= st_col_d;
    end
  end

endmodule

// File: rtl/core/stok_fifo.sv
// Token queue: takes up to two tokens a cycle, hands out one.
// Depends on stok_pkg.
module stok_fifo import stok_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output tok_t  head_o,
  output logic  valid_o,
  output logic  stall_o
);

  tok_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_next;
  logic [CNT_W-1:0] cnt_q;

  assign wr_next = wr_q + 1'b1;
  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  // two free slots are needed before the next transaction can be taken
  assign stall_o = (cnt_q > CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.n);
      rd_q  <= rd_q + PTR_W'(pop_i);
      cnt_q <= cnt_q + CNT_W'(push_i.n) - CNT_W'(pop_i);
    end
  end

endmodule

// File: rtl/core/source_tokenizer.sv
// Streaming source tokenizer, top level.
// Depends on stok_pkg, stok_lexer and stok_fifo.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+-------------------------------
//  in      | in_valid_i / in_stall_o         | input     | cmd_i, char_byte_i
//  out     | out_valid_o / out_stall_i       | output    | token_kind_o .. last_of_run_o
//
// One byte per cycle while in_stall_o is low: each accepted transaction is lexed in the
// cycle it is taken and its zero to two tokens are written to a four-entry token queue.
// A token is offered on the output once the tokens queued ahead of it have been taken.
// in_stall_o is high while the queue has fewer than two free entries.
// Reset clears the lexer state and empties the queue; no clearing pass.
module source_tokenizer import stok_pkg::*; #(
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [7:0]        char_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        token_kind_o,
  output logic [IDX_W-1:0]  start_index_o,
  output logic [LINE_W-1:0] start_line_o,
  output logic [COL_W-1:0]  start_column_o,
  output logic [LEN_W-1:0]  token_length_o,
  output logic [VAL_W-1:0]  integer_value_o,
  output logic              value_overflow_o,
  output logic              last_of_run_o
);

  logic  in_fire, out_fire;
  push_t push;
  tok_t  head;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  stok_lexer #(
    .INDEX_BITS  (INDEX_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .cmd_i       (cmd_i),
    .char_byte_i (char_byte_i),
    .push_o      (push)
  );

  stok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_fire),
    .head_o  (head),
    .valid_o (out_valid_o),
    .stall_o (in_stall_o)
  );

  assign token_kind_o     = head.kind;
  assign start_index_o    = head.start_index;
  assign start_line_o     = head.start_line;
  assign start_column_o   = head.start_column;
  assign token_length_o   = head.length;
  assign integer_value_o  = head.value;
  assign value_overflow_o = head.overflow;
  assign last_of_run_o    = head.last;

endmodule

// File: rtl/core/stok_checker.sv
// Port-level checks for source_tokenizer, attached by bind.
// Depends on stok_pkg.
module stok_checker import stok_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              cmd_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [2:0]        token_kind_o,
  input logic [IDX_W-1:0]  start_index_o,
  input logic [LINE_W-1:0] start_line_o,
  input logic [COL_W-1:0]  start_column_o,
  input logic [LEN_W-1:0]  token_length_o,
  input logic [VAL_W-1:0]  integer_value_o,
  input logic              value_overflow_o,
  input logic              last_of_run_o
);

  // a stalled token stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_index_o) && $stable(start_line_o) && $stable(start_column_o) &&
      $stable(token_length_o) && $stable(integer_value_o) &&
      $stable(value_overflow_o) && $stable(last_of_run_o))
    else $error("stalled output transaction changed");

  // an end-of-input transaction always yields a token next cycle
  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i |=> out_valid_o)
    else $error("no token after end of input");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_END) |->
      (token_length_o == '0) && last_of_run_o)
    else $error("end token malformed");

  a_value_only_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != KIND_INT) |->
      (integer_value_o == '0) && !value_overflow_o)
    else $error("value on non-integer token");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KIND_OP) || (token_kind_o == KIND_OPEN) ||
      (token_kind_o == KIND_CLOSE)) |-> (token_length_o == LEN_W'(1)))
    else $error("single-byte token with wrong length");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

// File: test/stok_token_checker.sv
// Token checker for the source tokenizer testbench: watches both channels,
// predicts the token stream from accepted bytes and compares every result.
// Depends on stok_pkg for the token record and kind codes.
`timescale 1ns / 100ps

module stok_token_checker import stok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              cmd_i,
  input  logic [7:0]        char_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [2:0]        token_kind_i,
  input  logic [IDX_W-1:0]  start_index_i,
  input  logic [LINE_W-1:0] start_line_i,
  input  logic [COL_W-1:0]  start_column_i,
  input  logic [LEN_W-1:0]  token_length_i,
  input  logic [VAL_W-1:0]  integer_value_i,
  input  logic              value_overflow_i,
  input  logic              last_of_run_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);

  localparam logic CMD_END = 1'b1;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_OPEN       = "(";
  localparam logic [7:0] CH_CLOSE      = ")";
  localparam logic [7:0] CH_STAR       = "*";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_SLASH      = "/";
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [7:0] CH_NINE       = "9";
  localparam logic [7:0] CH_COLON      = ":";
  localparam logic [7:0] CH_EQUALS     = "=";
  localparam logic [7:0] CH_UNDERSCORE = "_";

  localparam logic [VALUE_BITS_DEF-1:0] VALUE_MAX = {VALUE_BITS_DEF{1'b1}};

  typedef enum logic [1:0] {
    LEX_IDLE  = 2'd0,
    LEX_INT   = 2'd1,
    LEX_IDENT = 2'd2,
    LEX_COLON = 2'd3
  } lex_mode_e;

  lex_mode_e                  mode;
  logic [VALUE_BITS_DEF-1:0]  acc_value;
  logic                       acc_ovf;
  logic [INDEX_BITS_DEF-1:0]  pos_index;
  logic [LINE_BITS_DEF-1:0]   pos_line;
  logic [COLUMN_BITS_DEF-1:0] pos_column;
  logic [INDEX_BITS_DEF-1:0]  tok_index;
  logic [LINE_BITS_DEF-1:0]   tok_line;
  logic [COLUMN_BITS_DEF-1:0] tok_column;

  // last token of a transaction is held back until the transaction is done
  tok_t held_tok;
  logic held_valid;
  tok_t expected_tokens[$];

  function automatic logic is_decimal(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
  endfunction

  function automatic void mark_start();
    tok_index  = pos_index;
    tok_line   = pos_line;
    tok_column = pos_column;
  endfunction

  function automatic void advance_position(input logic [7:0] c);
    if (pos_index != '1) pos_index++;
    if (c == CH_NEWLINE) begin
      if (pos_line != '1) pos_line++;
      pos_column = '0;
    end else if (pos_column != '1) begin
      pos_column++;
    end
  endfunction

  function automatic void add_token(input kind_e kind, input logic [INDEX_BITS_DEF-1:0] len,
                                    input logic [VALUE_BITS_DEF-1:0] value, input logic ovf);
    tok_t t;
    t.kind         = kind;
    t.start_index  = tok_index;
    t.start_line   = tok_line;
    t.start_column = tok_column;
    t.length       = (len > {LEN_W{1'b1}}) ? {LEN_W{1'b1}} : len[LEN_W-1:0];
    t.value        = value;
    t.overflow     = ovf;
    t.last         = 1'b0;
    if (held_valid) expected_tokens.push_back(held_tok);
    held_tok   = t;
    held_valid = 1'b1;
  endfunction

  function automatic void flush_pending();
    case (mode)
      LEX_INT:   add_token(KIND_INT, pos_index - tok_index, acc_value, acc_ovf);
      LEX_IDENT: add_token(KIND_IDENT, pos_index - tok_index, '0, 1'b0);
      LEX_COLON: add_token(KIND_INVALID, pos_index - tok_index, '0, 1'b0);
      default: ;
    endcase
    mode = LEX_IDLE;
  endfunction

  function automatic void accumulate_digit(input logic [7:0] c);
    logic [VALUE_BITS_DEF-1:0] digit;
    digit = VALUE_BITS_DEF'(c - CH_ZERO);
    if (acc_ovf || acc_value > (VALUE_MAX - digit) / 10) begin
      acc_value = VALUE_MAX;
      acc_ovf   = 1'b1;
    end else begin
      acc_value = acc_value * 10 + digit;
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tok_t  want;
    kind_e single_kind;
    if (!rst_ni) begin
      mode         = LEX_IDLE;
      acc_value    = '0;
      acc_ovf      = 1'b0;
      pos_index    = '0;
      pos_line     = '0;
      pos_column   = '0;
      tok_index    = '0;
      tok_line     = '0;
      tok_column   = '0;
      held_valid   = 1'b0;
      fail_count_o = 0;
      expected_tokens.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $error("token kind %0d at index %0d with none expected", token_kind_i,
                 start_index_i);
          fail_count_o++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.kind, token_kind_i);
          check_field("start_index", want.start_index, start_index_i);
          check_field("start_line", want.start_line, start_line_i);
          check_field("start_column", want.start_column, start_column_i);
          check_field("token_length", want.length, token_length_i);
          check_field("integer_value", want.value, integer_value_i);
          check_field("value_overflow", want.overflow, value_overflow_i);
          check_field("last_of_run", want.last, last_of_run_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_END || char_byte_i == CH_NUL) begin
          // end token sits at the current position, which does not move
          flush_pending();
          mark_start();
          add_token(KIND_END, '0, '0, 1'b0);
        end else if (mode == LEX_INT && is_decimal(char_byte_i)) begin
          accumulate_digit(char_byte_i);
          advance_position(char_byte_i);
        end else if (mode == LEX_IDENT &&
                     (is_alpha(char_byte_i) || is_decimal(char_byte_i))) begin
          advance_position(char_byte_i);
        end else if (mode == LEX_COLON && char_byte_i == CH_EQUALS) begin
          advance_position(char_byte_i);
          add_token(KIND_ASSIGN, pos_index - tok_index, '0, 1'b0);
          mode = LEX_IDLE;
        end else begin
          // byte ends any pending token, then starts afresh
          flush_pending();
          if (char_byte_i == CH_SPACE || char_byte_i == CH_TAB || char_byte_i == CH_NEWLINE)
          begin
            advance_position(char_byte_i);
          end else if (is_decimal(char_byte_i)) begin
            mark_start();
            acc_value = '0;
            acc_ovf   = 1'b0;
            accumulate_digit(char_byte_i);
            advance_position(char_byte_i);
            mode = LEX_INT;
          end else if (is_alpha(char_byte_i)) begin
            mark_start();
            advance_position(char_byte_i);
            mode = LEX_IDENT;
          end else if (char_byte_i == CH_COLON) begin
            mark_start();
            advance_position(char_byte_i);
            mode = LEX_COLON;
          end else begin
            case (char_byte_i)
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: single_kind = KIND_OP;
              CH_OPEN:  single_kind = KIND_OPEN;
              CH_CLOSE: single_kind = KIND_CLOSE;
              default:  single_kind = KIND_INVALID;
            endcase
            mark_start();
            advance_position(char_byte_i);
            add_token(single_kind, INDEX_BITS_DEF'(1), '0, 1'b0);
          end
        end
        if (held_valid) begin
          held_tok.last = 1'b1;
          expected_tokens.push_back(held_tok);
          held_valid = 1'b0;
        end
      end
    end
    outstanding_o = expected_tokens.size();
  end

endmodule

// File: test/source_tokenizer_tb.sv
// Top of the source tokenizer testbench: clock, reset, byte stimulus,
// receiver stalls, watchdog and verdict. Depends on stok_pkg,
// source_tokenizer and stok_token_checker.
`timescale 1ns / 100ps

module source_tokenizer_tb;
  import stok_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 340;
  localparam int unsigned LONG_LINE    = 40;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IDENT_TAIL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string DIGITS     = "0123456789";
  localparam string OPERATORS  = "+-*/";
  localparam string PARENS     = "()";
  localparam string WHITESPACE = " \t\n";

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              cmd;
  logic [7:0]        char_byte;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        token_kind;
  logic [IDX_W-1:0]  start_index;
  logic [LINE_W-1:0] start_line;
  logic [COL_W-1:0]  start_column;
  logic [LEN_W-1:0]  token_length;
  logic [VAL_W-1:0]  integer_value;
  logic              value_overflow;
  logic              last_of_run;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_sent;
  logic        hold_request;

  source_tokenizer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .char_byte_i      (char_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .token_kind_o     (token_kind),
    .start_index_o    (start_index),
    .start_line_o     (start_line),
    .start_column_o   (start_column),
    .token_length_o   (token_length),
    .integer_value_o  (integer_value),
    .value_overflow_o (value_overflow),
    .last_of_run_o    (last_of_run)
  );

  stok_token_checker token_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .char_byte_i      (char_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .token_kind_i     (token_kind),
    .start_index_i    (start_index),
    .start_line_i     (start_line),
    .start_column_i   (start_column),
    .token_length_i   (token_length),
    .integer_value_i  (integer_value),
    .value_overflow_i (value_overflow),
    .last_of_run_i    (last_of_run),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic item_cmd, input logic [7:0] item_byte);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= item_cmd;
    char_byte <= item_byte;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input string text);
    foreach (text[i]) send_item(CMD_BYTE, text[i]);
  endtask

  // Mostly well-formed token text with random content, some noise and ends.
  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned first;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      case ($urandom_range(11))
        0, 1: begin
          send_item(CMD_BYTE, IDENT_HEAD[$urandom_range(IDENT_HEAD.len() - 1)]);
          repeat ($urandom_range(6))
            send_item(CMD_BYTE, IDENT_TAIL[$urandom_range(IDENT_TAIL.len() - 1)]);
        end
        2, 3: begin
          case ($urandom_range(9))
            0: send_word("4294967295");
            1: send_word("4294967296");
            2: repeat ($urandom_range(15, 11)) send_item(CMD_BYTE, DIGITS[$urandom_range(9)]);
            default: repeat ($urandom_range(3, 1)) send_item(CMD_BYTE, DIGITS[$urandom_range(9)]);
          endcase
        end
        4: send_item(CMD_BYTE, OPERATORS[$urandom_range(3)]);
        5: send_item(CMD_BYTE, PARENS[$urandom_range(1)]);
        6: send_word(":=");
        7, 8: repeat ($urandom_range(2, 1)) send_item(CMD_BYTE, WHITESPACE[$urandom_range(2)]);
        9: send_item(CMD_BYTE, 8'($urandom_range(255)));
        10: send_item(CMD_BYTE, ":");
        default: begin
          if ($urandom_range(1)) send_item(CMD_END, 8'($urandom_range(255)));
          else send_item(CMD_BYTE, 8'h00);
        end
      endcase
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: ends the run after too long without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("source_tokenizer_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = CMD_BYTE;
    char_byte    = 8'h00;
    hold_request = 1'b0;
    tx_idle_pct  = 31;
    rx_idle_pct  = 85;
    items_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every token kind, white space, lone colons, bad bytes, both ends
    send_word("Zz_0 :=(9)\t-+*/\n:x");
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, ":");
    send_item(CMD_END, 8'hA5);
    send_word("7");
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_END, 8'h00);

    run_phase(31, 85);
    run_phase(85, 31);
    hold_request = 1'b1;
    run_phase(0, 0);

    // one long identifier and a number after it, then a number on a fresh line
    repeat (LONG_LINE) send_item(CMD_BYTE, "a");
    send_word(" 1\n2");
    send_item(CMD_END, 8'h3C);
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("source_tokenizer_tb: PASS");
    end else begin
      $display("source_tokenizer_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stok_pkg.sv
rtl/core/stok_lexer.sv
rtl/core/stok_fifo.sv
rtl/core/source_tokenizer.sv
rtl/core/stok_checker.sv
test/stok_token_checker.sv
test/source_tokenizer_tb.sv
